FILE: hdl/qenc_pkg.sv
// Shared types and constants for the quadrature encoder event decoder.
// Used by qenc_ctrl, qenc_dp and event_quadrature_encoder_decoder.
package qenc_pkg;

    localparam int NUM_ENC_DEF = 4;
    localparam int MAP_REGS    = 4;

    localparam int BYTE_W  = 8;
    localparam int ACT_W   = 3;
    localparam int MAP_W   = 48;
    localparam int CMD_W   = 3;
    localparam int IDX_W   = 3;
    localparam int ROLE_W  = 2;
    localparam int EDGE_W  = 3;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    // register indexes
    localparam logic [IDX_W-1:0] REG_ACTIVE = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAP0   = 3'd1;

    localparam logic [BYTE_W-1:0] EV_RISING = 8'd4;

    // last edge codes
    localparam logic [EDGE_W-1:0] EDGE_A_UP = 3'd0;
    localparam logic [EDGE_W-1:0] EDGE_A_DN = 3'd1;
    localparam logic [EDGE_W-1:0] EDGE_B_UP = 3'd2;
    localparam logic [EDGE_W-1:0] EDGE_B_DN = 3'd3;
    localparam logic [EDGE_W-1:0] EDGE_NONE = 3'd4;

    // result commands
    localparam logic [CMD_W-1:0] CMD_LEFT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RIGHT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BUTTON = 3'd2;

    // device roles checked per entry
    localparam logic [ROLE_W-1:0] ROLE_A = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_B = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_C = 2'd2;

    typedef struct packed {
        logic start;
        logic step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic             p_valid;
        logic             out_free;
        logic [ACT_W-1:0] limit;
    } t_stat;

endpackage

FILE: hdl/event_quadrature_encoder_decoder.sv
// Top level of the edge-event quadrature encoder decoder.
// Depends on qenc_pkg, qenc_ctrl and qenc_dp.
//
//  port group   dir  contents
//  i_cfg_*      in   register write: index, 48-bit data
//  s_axis_*     in   edge event: src_module, src_device, event_code
//  m_axis_*     out  result: dest_module, dest_address, command; tlast
//
// An event is accepted in S_IDLE and ends there if no entry is in use; else the
// walk takes one step per entry in use and device role (A, B, C), and S_FLUSH
// then releases the final result, if any. The walk through the entries is the limiting loop.
// A result waiting in the output register with m_axis_tready low stalls the
// walk only once a second result is ready to move out.
// Reset clears configuration and marks every entry with no edge seen.
module event_quadrature_encoder_decoder #(
    parameter int NUM_ENC = qenc_pkg::NUM_ENC_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [qenc_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [qenc_pkg::MAP_W-1:0]    i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // src_module, src_device, event_code
    input  logic [qenc_pkg::S_DATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // dest_module, dest_address, command, zero pad
    output logic [qenc_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast
);

    localparam int ENTRIES = (NUM_ENC < qenc_pkg::MAP_REGS) ? NUM_ENC : qenc_pkg::MAP_REGS;
    localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    qenc_pkg::t_cmd                 cmd;
    qenc_pkg::t_stat                stat;
    logic [IW-1:0]                  idx;
    logic [qenc_pkg::ROLE_W-1:0]    role;

    qenc_ctrl #(
        .IW (IW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_idx      (idx),
        .o_role     (role)
    );

    qenc_dp #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .i_role      (role),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

FILE: hdl/qenc_ctrl.sv
// Sequencer for the encoder decoder: walks entries and device roles.
// Depends on qenc_pkg; drives qenc_dp through t_cmd, reads t_stat.
module qenc_ctrl #(
    parameter int IW = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  qenc_pkg::t_stat       i_stat,
    output qenc_pkg::t_cmd        o_cmd,
    output logic [IW-1:0]         o_idx,
    output logic [qenc_pkg::ROLE_W-1:0] o_role
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]                    r_state, n_state;
    logic [IW-1:0]                 r_idx, n_idx;
    logic [qenc_pkg::ROLE_W-1:0]   r_role, n_role;
    logic                          go;
    logic                          last_entry;

    assign go         = !i_stat.p_valid || i_stat.out_free;
    assign last_entry = (qenc_pkg::ACT_W'(r_idx) + 3'd1) == i_stat.limit;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_role     = r_role;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_idx       = '0;
                    n_role      = qenc_pkg::ROLE_A;
                    if (i_stat.limit != '0) begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (go) begin
                    o_cmd.step = 1'b1;
                    if (r_role == qenc_pkg::ROLE_C) begin
                        n_role = qenc_pkg::ROLE_A;
                        n_idx  = r_idx + 1'b1;
                        if (last_entry) begin
                            n_state = S_FLUSH;
                        end
                    end else begin
                        n_role = r_role + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_stat.p_valid) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_role  <= qenc_pkg::ROLE_A;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_role  <= n_role;
        end
    end

    assign o_idx  = r_idx;
    assign o_role = r_role;

endmodule

FILE: hdl/qenc_dp.sv
// Datapath: configuration registers, per-entry last edge, pending result
// and output register. Depends on qenc_pkg; commanded by qenc_ctrl.
module qenc_dp #(
    parameter int ENTRIES = 4,
    parameter int IW      = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [qenc_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [qenc_pkg::MAP_W-1:0]        i_cfg_wdata,
    input  logic [qenc_pkg::S_DATA_W-1:0]     i_in_data,
    input  qenc_pkg::t_cmd                    i_cmd,
    input  logic [IW-1:0]                     i_idx,
    input  logic [qenc_pkg::ROLE_W-1:0]       i_role,
    output qenc_pkg::t_stat                   o_stat,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [qenc_pkg::M_DATA_W-1:0]     o_out_data,
    output logic                              o_out_last
);

    localparam int BW = qenc_pkg::BYTE_W;

    logic [qenc_pkg::ACT_W-1:0]  r_active;
    logic [qenc_pkg::MAP_W-1:0]  r_map  [ENTRIES];
    logic [qenc_pkg::EDGE_W-1:0] r_edge [ENTRIES];

    logic [BW-1:0] r_mod, r_dev, r_code;

    logic                       r_pvalid;
    logic [BW-1:0]              r_pmod, r_paddr;
    logic [qenc_pkg::CMD_W-1:0] r_pcmd;

    logic                       r_ovalid;
    logic [BW-1:0]              r_omod, r_oaddr;
    logic [qenc_pkg::CMD_W-1:0] r_ocmd;
    logic                       r_olast;

    logic [qenc_pkg::MAP_W-1:0]  map;
    logic [qenc_pkg::EDGE_W-1:0] edge_cur, n_edge;
    logic [BW-1:0]               role_dev;
    logic                        rising, hit, produce, edge_we, load_out;
    logic [qenc_pkg::CMD_W-1:0]  new_cmd;

    assign map      = r_map[i_idx];
    assign edge_cur = r_edge[i_idx];
    assign rising   = (r_code == qenc_pkg::EV_RISING);

    always_comb begin
        case (i_role)
            qenc_pkg::ROLE_A: role_dev = map[2*BW-1:BW];
            qenc_pkg::ROLE_B: role_dev = map[3*BW-1:2*BW];
            default:          role_dev = map[4*BW-1:3*BW];
        endcase
    end

    assign hit = (map[BW-1:0] == r_mod) && (role_dev == r_dev);

    always_comb begin
        produce = 1'b0;
        edge_we = 1'b0;
        n_edge  = edge_cur;
        new_cmd = qenc_pkg::CMD_LEFT;
        case (i_role)
            qenc_pkg::ROLE_A: begin
                edge_we = hit;
                n_edge  = rising ? qenc_pkg::EDGE_A_UP : qenc_pkg::EDGE_A_DN;
                produce = hit && (edge_cur ==
                          (rising ? qenc_pkg::EDGE_B_UP : qenc_pkg::EDGE_B_DN));
                new_cmd = qenc_pkg::CMD_LEFT;
            end
            qenc_pkg::ROLE_B: begin
                edge_we = hit;
                n_edge  = rising ? qenc_pkg::EDGE_B_UP : qenc_pkg::EDGE_B_DN;
                produce = hit && (edge_cur ==
                          (rising ? qenc_pkg::EDGE_A_UP : qenc_pkg::EDGE_A_DN));
                new_cmd = qenc_pkg::CMD_RIGHT;
            end
            qenc_pkg::ROLE_C: begin
                produce = hit;
                new_cmd = qenc_pkg::CMD_BUTTON + {1'b0, r_code[3:2]};
            end
            default: begin
                produce = 1'b0;
            end
        endcase
    end

    assign load_out = r_pvalid && ((i_cmd.step && produce) || i_cmd.flush);

    always_comb begin
        o_stat.p_valid  = r_pvalid;
        o_stat.out_free = !r_ovalid || i_out_ready;
        if (r_active > qenc_pkg::ACT_W'(ENTRIES)) begin
            o_stat.limit = qenc_pkg::ACT_W'(ENTRIES);
        end else begin
            o_stat.limit = r_active;
        end
    end

    // configuration and per-entry state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cfg_we && i_cfg_index == qenc_pkg::REG_ACTIVE) begin
            r_active <= i_cfg_wdata[qenc_pkg::ACT_W-1:0];
        end
    end

    for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_map[k]  <= '0;
                r_edge[k] <= qenc_pkg::EDGE_NONE;
            end else begin
                if (i_cfg_we &&
                    i_cfg_index == qenc_pkg::REG_MAP0 + qenc_pkg::IDX_W'(k)) begin
                    r_map[k] <= i_cfg_wdata;
                end
                if (i_cmd.step && edge_we && i_idx == IW'(k)) begin
                    r_edge[k] <= n_edge;
                end
            end
        end
    end

    // input latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mod  <= i_in_data[BW-1:0];
            r_dev  <= i_in_data[2*BW-1:BW];
            r_code <= i_in_data[3*BW-1:2*BW];
        end
    end

    // pending result: held until it is known whether another one follows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else if (i_cmd.step && produce) begin
            r_pvalid <= 1'b1;
        end else if (i_cmd.flush) begin
            r_pvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && produce) begin
            r_pmod  <= map[5*BW-1:4*BW];
            r_paddr <= map[6*BW-1:5*BW];
            r_pcmd  <= new_cmd;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_omod  <= r_pmod;
            r_oaddr <= r_paddr;
            r_ocmd  <= r_pcmd;
            r_olast <= i_cmd.flush;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = {5'd0, r_ocmd, r_oaddr, r_omod};
    assign o_out_last  = r_olast;

endmodule

FILE: tb/tb_event_quadrature_encoder_decoder.sv
`timescale 1ns / 100ps
// Self-checking testbench for event_quadrature_encoder_decoder: drives edge events and
// register writes, predicts every step and button result and checks them in order.
// Depends on qenc_pkg and the RTL of the block only.
module tb_event_quadrature_encoder_decoder;
    import qenc_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE_FIRST = IDX_W'(REG_MAP0 + MAP_REGS);
    localparam logic [IDX_W-1:0] REG_SPARE_LAST  = '1;
    localparam int DRAIN_CYCLES = 20;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int NUM_PHASES = 7;

    typedef struct packed {
        logic [BYTE_W-1:0] dmod;
        logic [BYTE_W-1:0] daddr;
        logic [CMD_W-1:0]  cmd;
        logic              last;
    } t_result;

    class encoder_scoreboard;
        logic [ACT_W-1:0]  active;
        logic [MAP_W-1:0]  enc_map[MAP_REGS];
        logic [EDGE_W-1:0] last_edge[NUM_ENC_DEF];
        t_result           pending[$];
        int                n_err;
        int                n_events;
        int                n_results;

        function new();
            active = '0;
            foreach (enc_map[k]) enc_map[k] = '0;
            foreach (last_edge[k]) last_edge[k] = EDGE_NONE;
            n_err = 0;
            n_events = 0;
            n_results = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [MAP_W-1:0] data);
            if (idx == REG_ACTIVE) begin
                active = data[ACT_W-1:0];
            end else if (idx >= REG_MAP0 && idx < REG_SPARE_FIRST) begin
                if (idx - REG_MAP0 < NUM_ENC_DEF) enc_map[idx - REG_MAP0] = data;
            end
        endfunction

        function void note_event(logic [BYTE_W-1:0] mod, logic [BYTE_W-1:0] dev,
                                 logic [BYTE_W-1:0] code);
            logic             rising;
            int               lim;
            logic [MAP_W-1:0] m;
            t_result          r;
            t_result          batch[$];
            rising = (code == EV_RISING);
            lim = active;
            if (lim > NUM_ENC_DEF) lim = NUM_ENC_DEF;
            if (lim > MAP_REGS) lim = MAP_REGS;
            n_events++;
            for (int k = 0; k < lim; k++) begin
                m = enc_map[k];
                if (m[7:0] != mod) continue;
                r.dmod  = m[39:32];
                r.daddr = m[47:40];
                r.last  = 1'b0;
                if (m[15:8] == dev) begin
                    if (last_edge[k] == (rising ? EDGE_B_UP : EDGE_B_DN)) begin
                        r.cmd = CMD_LEFT;
                        batch.push_back(r);
                    end
                    last_edge[k] = rising ? EDGE_A_UP : EDGE_A_DN;
                end
                if (m[23:16] == dev) begin
                    if (last_edge[k] == (rising ? EDGE_A_UP : EDGE_A_DN)) begin
                        r.cmd = CMD_RIGHT;
                        batch.push_back(r);
                    end
                    last_edge[k] = rising ? EDGE_B_UP : EDGE_B_DN;
                end
                if (m[31:24] == dev) begin
                    r.cmd = CMD_BUTTON + CMD_W'(code[3:2]);
                    batch.push_back(r);
                end
            end
            for (int j = 0; j < batch.size(); j++) begin
                r = batch[j];
                r.last = (j == batch.size() - 1);
                pending.push_back(r);
            end
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data, logic last);
            t_result want;
            if (pending.size() == 0) begin
                $error("unexpected result transfer: tdata %h tlast %0b", data, last);
                n_err++;
                return;
            end
            want = pending.pop_front();
            n_results++;
            if (data[7:0] !== want.dmod) begin
                $error("dest_module: expected %0d, actual %0d", want.dmod, data[7:0]);
                n_err++;
            end
            if (data[15:8] !== want.daddr) begin
                $error("dest_address: expected %0d, actual %0d", want.daddr, data[15:8]);
                n_err++;
            end
            if (data[18:16] !== want.cmd) begin
                $error("command: expected %0d, actual %0d", want.cmd, data[18:16]);
                n_err++;
            end
            if (last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, last);
                n_err++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [IDX_W-1:0]     i_cfg_index;
    logic [MAP_W-1:0]     i_cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_DATA_W-1:0]  m_axis_tdata;
    logic                 m_axis_tlast;

    encoder_scoreboard sb = new();
    int  hold_cycles = 0;
    int  rx_stall = 0;
    bit  rx_free = 0;
    bit  tx_free = 0;
    int  n_settings = 0;

    event_quadrature_encoder_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    // receiver: random stalls, free-running stretches and a counted long hold-off
    initial begin
        int roll;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end else if (rx_free) begin
                m_axis_tready <= 1'b1;
            end else if (rx_stall > 0) begin
                m_axis_tready <= 1'b0;
                rx_stall--;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    rx_stall = (roll < 93) ? $urandom_range(0, 2) : $urandom_range(8, 30);
                    m_axis_tready <= 1'b0;
                end
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (tx_free || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [MAP_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_event(input logic [BYTE_W-1:0] mod, input logic [BYTE_W-1:0] dev,
                              input logic [BYTE_W-1:0] code);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {code, dev, mod};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_event(mod, dev, code);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] falling_code();
        logic [BYTE_W-1:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == EV_RISING) c = '0;
        return c;
    endfunction

    task automatic random_setup(input logic [ACT_W-1:0] act);
        logic [BYTE_W-1:0] pool[4];
        logic [BYTE_W-1:0] in0;
        logic [BYTE_W-1:0] in_mod;
        logic [63:0]       wide;
        int                ia;
        int                ib;
        foreach (pool[j]) pool[j] = 8'($urandom_range(0, 255));
        in0 = 8'($urandom_range(0, 255));
        cfg_write(REG_ACTIVE, MAP_W'(act));
        for (int k = 0; k < MAP_REGS; k++) begin
            in_mod = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : in0;
            ia = $urandom_range(0, 3);
            ib = ($urandom_range(0, 5) == 0) ? ia : (ia + $urandom_range(1, 3)) % 4;
            cfg_write(IDX_W'(REG_MAP0 + k),
                      {16'($urandom_range(0, 65535)), pool[$urandom_range(0, 3)],
                       pool[ib], pool[ia], in_mod});
        end
        if ($urandom_range(0, 1) == 0) begin
            wide = {$urandom(), $urandom()};
            cfg_write(IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), wide[MAP_W-1:0]);
        end
        n_settings++;
    endtask

    task automatic random_event();
        logic [MAP_W-1:0] m;
        logic [31:0]      noise;
        int               roll;
        m = sb.enc_map[$urandom_range(0, MAP_REGS - 1)];
        roll = $urandom_range(0, 99);
        noise = $urandom();
        if (roll < 40)
            send_event(m[7:0], m[15:8], $urandom_range(0, 1) ? EV_RISING : falling_code());
        else if (roll < 80)
            send_event(m[7:0], m[23:16], $urandom_range(0, 1) ? EV_RISING : falling_code());
        else if (roll < 88)
            send_event(m[7:0], m[31:24], 8'($urandom_range(0, 255)));
        else
            send_event(noise[7:0], noise[15:8], noise[23:16]);
    endtask

    initial begin
        logic [ACT_W-1:0] acts[NUM_PHASES];
        logic [63:0]      wide;
        acts = '{3'd4, 3'd7, 3'd1, 3'd3, 3'd2, 3'd5, 3'd4};
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // out of reset: no entries in use
        send_event(8'h00, 8'h00, 8'h00);
        send_event(8'hFF, 8'hFF, 8'hFF);
        wait_drained();

        // directed: count above the table size, shared devices, one device on all roles
        cfg_write(REG_ACTIVE, MAP_W'(3'd7));
        cfg_write(REG_MAP0,               48'h00FF_0302_0100);
        cfg_write(IDX_W'(REG_MAP0 + 1),   48'hFF5A_FFFF_FFFF);
        cfg_write(IDX_W'(REG_MAP0 + 2),   48'h8142_0402_0100);
        cfg_write(IDX_W'(REG_MAP0 + 3),   48'h7E00_8001_0200);
        for (int k = REG_SPARE_FIRST; k <= REG_SPARE_LAST; k++)
            cfg_write(IDX_W'(k), '1);
        n_settings++;
        send_event(8'h00, 8'h01, EV_RISING);
        send_event(8'h00, 8'h02, EV_RISING);
        send_event(8'h00, 8'h01, 8'h00);
        send_event(8'h00, 8'h02, 8'h80);
        send_event(8'h00, 8'h02, EV_RISING);
        send_event(8'h00, 8'h01, EV_RISING);
        send_event(8'h00, 8'h03, 8'h00);
        send_event(8'h00, 8'h03, 8'h04);
        send_event(8'h00, 8'h03, 8'h08);
        send_event(8'h00, 8'h03, 8'h0C);
        send_event(8'h00, 8'h04, 8'hF3);
        send_event(8'hFF, 8'hFF, EV_RISING);
        send_event(8'hFF, 8'hFF, EV_RISING);
        send_event(8'hFF, 8'hFF, 8'hFF);
        send_event(8'hFF, 8'hFF, 8'h40);
        send_event(8'h07, 8'h01, EV_RISING);
        send_event(8'h00, 8'h80, 8'h10);
        wait_drained();

        // every entry on one device: twelve results per repeated-polarity event,
        // receiver held off
        cfg_write(REG_ACTIVE, MAP_W'(3'd4));
        for (int k = 0; k < MAP_REGS; k++)
            cfg_write(IDX_W'(REG_MAP0 + k), {8'hA5, 8'(k), 8'h10, 8'h10, 8'h10, 8'h20});
        n_settings++;
        tx_free = 1;
        hold_cycles = 300;
        for (int j = 0; j < 8; j++)
            send_event(8'h20, 8'h10, j[1] ? 8'h2C : EV_RISING);
        wait_drained();
        tx_free = 0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            random_setup(acts[p]);
            rx_free = (p == 3);
            tx_free = (p == 3);
            if (p == 5) hold_cycles = 200;
            for (int j = 0; j < ITEMS_PER_PHASE; j++) begin
                if (p == 1 && j == ITEMS_PER_PHASE / 2) begin
                    @(negedge i_clk);
                    s_axis_tvalid <= 1'b0;
                    while (sb.pending.size() != 0) @(posedge i_clk);
                end
                random_event();
            end
            wait_drained();
        end
        rx_free = 0;
        tx_free = 0;

        $display("Checked %0d results from %0d edge events over %0d register settings,",
                 sb.n_results, sb.n_events, n_settings);
        $display("including full fan-out events, long output stalls and no-match noise.");
        if (sb.n_err == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

FILE: event_quadrature_encoder_decoder.f
hdl/qenc_pkg.sv
hdl/qenc_ctrl.sv
hdl/qenc_dp.sv
hdl/event_quadrature_encoder_decoder.sv
tb/tb_event_quadrature_encoder_decoder.sv
